/* sv/ssp_pkg.sv */
// Shared types and constants for the stepper setpoint speed planner.
package ssp_pkg;

  // Width of the period dividend: 1e6 us * 2^12 * 2^8 needs 40 bits.
  localparam int NUM_W = 40;
  localparam logic [NUM_W-1:0] PERIOD_NUM = 40'd1048576000000;
  localparam int MAX_SPEED_LOG2_DEF = 20;
  localparam int DIV_STEPS = NUM_W;

  localparam logic        PASSTHROUGH_RST = 1'b0;
  localparam logic [31:0] UNITS_RST       = 32'd65536;
  localparam logic [31:0] DEF_SPEED_RST   = 32'd6553600;

  typedef enum logic [1:0] {
    CFG_PASSTHROUGH = 2'd0,
    CFG_UNITS       = 2'd1,
    CFG_DEF_SPEED   = 2'd2
  } cfg_idx_t;

  // Result fields that ride along the divider chain unchanged.
  typedef struct packed {
    logic        ok;
    logic [31:0] target;
  } side_t;

  // One step of the actual-speed division: partial remainder, quotient, divisor.
  typedef struct packed {
    logic [31:0]      rem;
    logic [NUM_W-1:0] quo;
    logic [31:0]      div;
  } adiv_t;

endpackage

/* sv/ssp_front.sv */
// Front pipeline: magnitudes, products, target, commanded speed and dividends.
module ssp_front #(
  parameter int MAX_SPEED_LOG2 = ssp_pkg::MAX_SPEED_LOG2_DEF,
  parameter int VW = MAX_SPEED_LOG2 + 9
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [31:0]              setpoint_position,
  input  logic [31:0]              setpoint_rate,
  input  logic [31:0]              current_steps,
  input  logic [31:0]              current_period,
  input  logic                     fault_latched,
  input  logic                     passthrough_enable,
  input  logic [31:0]              units_to_steps,
  input  logic [31:0]              default_speed,
  output logic                     out_valid,
  output ssp_pkg::side_t           side,
  output logic [VW-1:0]            speed,
  output logic [ssp_pkg::NUM_W-1:0] period_num,
  output logic [31:0]              cper,
  output logic [ssp_pkg::NUM_W-1:0] actual_num
);
  import ssp_pkg::*;

  localparam logic [VW-1:0] VMAX = VW'(1) << (MAX_SPEED_LOG2 + 8);
  localparam logic [46:0] VMAX_W = 47'(VMAX);
  localparam logic [46:0] VMIN_W = 47'd256;

  // Stage 1: magnitudes and the accept decision.
  logic        v1, ok1, neg1;
  logic [31:0] pmag1, rmag1, scale1, def1, cur1, cper1;
  // Stage 2: products.
  logic        v2, ok2, neg2;
  logic [63:0] pp2, rp2, dp2;
  logic [31:0] cur2, cper2;
  // Stage 3: target and Q.8 speeds.
  logic        v3, ok3;
  logic [31:0] target3, cur3, cper3;
  logic [40:0] ff3, def3;
  // Stage 4: position error and cap.
  logic        v4, ok4;
  logic [31:0] target4, err4, cper4;
  logic [40:0] ff4, lim4;
  // Stage 5: uncapped speed.
  logic        v5, ok5;
  logic [31:0] target5, cper5;
  logic [46:0] sum5, lim5;
  // Stage 6: final speed.
  logic        v6, ok6;
  logic [31:0] target6, cper6;
  logic [VW-1:0] spd6;

  logic [64:0] tround;
  logic [32:0] tmag;
  logic [31:0] target_c;
  logic [32:0] diff;
  logic [46:0] capped;

  always_comb begin
    tround = {1'b0, pp2} + 65'h0_8000_0000;
    tmag = tround[64:32];
    if (neg2) begin
      target_c = (tmag > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(~tmag + 33'd1);
    end else begin
      target_c = (tmag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : tmag[31:0];
    end
    diff = {target3[31], target3} - {cur3[31], cur3};
    capped = (sum5 > lim5) ? lim5 : sum5;
    if (capped < VMIN_W) begin
      capped = VMIN_W;
    end
    if (capped > VMAX_W) begin
      capped = VMAX_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1    <= passthrough_enable && !fault_latched && (units_to_steps != 32'd0);
      neg1   <= setpoint_position[31] ^ units_to_steps[31];
      pmag1  <= setpoint_position[31] ? (~setpoint_position + 32'd1) : setpoint_position;
      rmag1  <= setpoint_rate[31] ? (~setpoint_rate + 32'd1) : setpoint_rate;
      scale1 <= units_to_steps[31] ? (~units_to_steps + 32'd1) : units_to_steps;
      def1   <= default_speed;
      cur1   <= current_steps;
      cper1  <= current_period;

      ok2 <= ok1; neg2 <= neg1; cur2 <= cur1; cper2 <= cper1;
      pp2 <= pmag1 * scale1;
      rp2 <= rmag1 * scale1;
      dp2 <= def1 * scale1;

      ok3 <= ok2; cur3 <= cur2; cper3 <= cper2;
      target3 <= target_c;
      ff3  <= {1'b0, rp2[63:24]} + 41'(rp2[23]);
      def3 <= {1'b0, dp2[63:24]} + 41'(dp2[23]);

      ok4 <= ok3; target4 <= target3; cper4 <= cper3; ff4 <= ff3;
      err4 <= diff[32] ? 32'(~diff + 33'd1) : diff[31:0];
      lim4 <= (ff3 > def3) ? ff3 : def3;

      ok5 <= ok4; target5 <= target4; cper5 <= cper4;
      // Twenty times the error in Q.8 is err * 5120.
      sum5 <= 47'(ff4) + (47'(err4) << 12) + (47'(err4) << 10);
      lim5 <= 47'(lim4);

      ok6 <= ok5; target6 <= target5; cper6 <= cper5;
      spd6 <= VW'(capped);

      side.ok     <= ok6;
      side.target <= target6;
      speed       <= spd6;
      period_num  <= PERIOD_NUM + NUM_W'(spd6 >> 1);
      cper        <= cper6;
      actual_num  <= PERIOD_NUM + NUM_W'(cper6 >> 1);
    end
  end

endmodule

/* sv/ssp_cell.sv */
// One divider cell: a single restoring step of both divisions per cycle while en is high.
module ssp_cell #(
  parameter int VW = ssp_pkg::MAX_SPEED_LOG2_DEF + 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      valid_i,
  input  ssp_pkg::side_t            side_i,
  input  logic [VW-1:0]             prem_i,
  input  logic [ssp_pkg::NUM_W-1:0] pquo_i,
  input  logic [VW-1:0]             pdiv_i,
  input  ssp_pkg::adiv_t            adiv_i,
  output logic                      valid_o,
  output ssp_pkg::side_t            side_o,
  output logic [VW-1:0]             prem_o,
  output logic [ssp_pkg::NUM_W-1:0] pquo_o,
  output logic [VW-1:0]             pdiv_o,
  output ssp_pkg::adiv_t            adiv_o
);
  import ssp_pkg::*;

  logic [VW:0] ps;
  logic        pge;
  logic [32:0] as;
  logic        age;

  always_comb begin
    ps  = {prem_i, pquo_i[NUM_W-1]};
    pge = ps >= {1'b0, pdiv_i};
    as  = {adiv_i.rem, adiv_i.quo[NUM_W-1]};
    age = as >= {1'b0, adiv_i.div};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o     <= side_i;
      prem_o     <= pge ? VW'(ps - {1'b0, pdiv_i}) : ps[VW-1:0];
      pquo_o     <= {pquo_i[NUM_W-2:0], pge};
      pdiv_o     <= pdiv_i;
      adiv_o.rem <= age ? 32'(as - {1'b0, adiv_i.div}) : as[31:0];
      adiv_o.quo <= {adiv_i.quo[NUM_W-2:0], age};
      adiv_o.div <= adiv_i.div;
    end
  end

endmodule

/* sv/stepper_setpoint_speed_planner.sv */
// A result passes through the front pipeline, the divider chain and the ramp stages in turn.
// Throughput: one setpoint per cycle; the 40-cell divider chain sets the depth.
// The whole pipeline advances together and holds while the output is stalled.
// Synchronous reset empties the pipeline and loads the register defaults:
// passthrough off, conversion 1.0 and default speed 100.0.
module stepper_setpoint_speed_planner #(
  parameter int MAX_SPEED_LOG2 = ssp_pkg::MAX_SPEED_LOG2_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] setpoint_position,
  input  logic [31:0] setpoint_rate,
  input  logic [31:0] current_steps,
  input  logic [31:0] current_period,
  input  logic        fault_latched,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic [31:0] target_steps,
  output logic [28:0] desired_speed,
  output logic [31:0] desired_period,
  output logic [39:0] ramp_accel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ssp_pkg::*;

  localparam int VW = MAX_SPEED_LOG2 + 9;
  localparam logic [NUM_W-1:0] VMAX = NUM_W'(1) << (MAX_SPEED_LOG2 + 8);

  logic        passthrough_enable;
  logic [31:0] units_to_steps;
  logic [31:0] default_speed;
  logic        en;

  assign cfg_ready = 1'b1;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      passthrough_enable <= PASSTHROUGH_RST;
      units_to_steps     <= UNITS_RST;
      default_speed      <= DEF_SPEED_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PASSTHROUGH: passthrough_enable <= cfg_data[0];
        CFG_UNITS:       units_to_steps <= cfg_data;
        CFG_DEF_SPEED:   default_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                 valid_c [DIV_STEPS+1];
  side_t                side_c  [DIV_STEPS+1];
  logic [VW-1:0]        prem_c  [DIV_STEPS+1];
  logic [NUM_W-1:0]     pquo_c  [DIV_STEPS+1];
  logic [VW-1:0]        pdiv_c  [DIV_STEPS+1];
  adiv_t                adiv_c  [DIV_STEPS+1];
  logic [NUM_W-1:0]     anum;
  logic [31:0]          cper_f;

  ssp_front #(.MAX_SPEED_LOG2(MAX_SPEED_LOG2), .VW(VW)) u_front (
    .clk, .rst, .en, .in_valid,
    .setpoint_position, .setpoint_rate, .current_steps, .current_period, .fault_latched,
    .passthrough_enable, .units_to_steps, .default_speed,
    .out_valid  (valid_c[0]),
    .side       (side_c[0]),
    .speed      (pdiv_c[0]),
    .period_num (pquo_c[0]),
    .cper       (cper_f),
    .actual_num (anum)
  );

  assign prem_c[0]     = '0;
  assign adiv_c[0].rem = '0;
  assign adiv_c[0].quo = anum;
  assign adiv_c[0].div = cper_f;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    ssp_cell #(.VW(VW)) u_cell (
      .clk, .rst, .en,
      .valid_i (valid_c[i]),   .side_i (side_c[i]),
      .prem_i  (prem_c[i]),    .pquo_i (pquo_c[i]),
      .pdiv_i  (pdiv_c[i]),    .adiv_i (adiv_c[i]),
      .valid_o (valid_c[i+1]), .side_o (side_c[i+1]),
      .prem_o  (prem_c[i+1]),  .pquo_o (pquo_c[i+1]),
      .pdiv_o  (pdiv_c[i+1]),  .adiv_o (adiv_c[i+1])
    );
  end

  // Ramp speed: the larger of commanded and actual speed, then capped.
  logic [NUM_W-1:0] spd_w, vr_w;
  always_comb begin
    spd_w = NUM_W'(pdiv_c[DIV_STEPS]);
    vr_w  = spd_w;
    if ((adiv_c[DIV_STEPS].div != 32'd0) && (adiv_c[DIV_STEPS].quo > spd_w)) begin
      vr_w = adiv_c[DIV_STEPS].quo;
    end
    if (vr_w > VMAX) begin
      vr_w = VMAX;
    end
  end

  logic          vx, vy;
  side_t         side_x, side_y;
  logic [VW-1:0] spd_x, spd_y, vr_x;
  logic [31:0]   per_x, per_y;
  logic [2*VW-1:0] sq_y;
  logic [2*VW:0]   acc_sum;

  assign acc_sum = {1'b0, sq_y} + (2*VW+1)'(1 << 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      vx <= 1'b0; vy <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      vx <= valid_c[DIV_STEPS]; vy <= vx; out_valid <= vy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_x <= side_c[DIV_STEPS];
      spd_x  <= pdiv_c[DIV_STEPS];
      per_x  <= pquo_c[DIV_STEPS][31:0];
      vr_x   <= VW'(vr_w);

      side_y <= side_x;
      spd_y  <= spd_x;
      per_y  <= per_x;
      sq_y   <= vr_x * vr_x;

      // A rejected setpoint reports zeros in every field.
      accepted       <= side_y.ok;
      target_steps   <= side_y.ok ? side_y.target : 32'd0;
      desired_speed  <= side_y.ok ? 29'(spd_y) : 29'd0;
      desired_period <= side_y.ok ? per_y : 32'd0;
      ramp_accel     <= side_y.ok ? 40'(acc_sum >> 17) : 40'd0;
    end
  end

`ifndef ASSERT_OFF
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && !accepted |-> target_steps == 32'd0 && desired_speed == 29'd0 &&
      desired_period == 32'd0 && ramp_accel == 40'd0)
    else $error("rejected setpoint carries nonzero fields");
  a_period_nonzero: assert property (@(posedge clk) disable iff (rst)
      out_valid && accepted |-> desired_period != 32'd0)
    else $error("accepted setpoint with zero period");
`endif

endmodule
